// ===== rtl/serial_bank_mapper_macros.svh =====
// Assertion macros for the serial bank mapper.
// Included by files that carry concurrent checks; uses clk_i and rst_ni.
`ifndef SERIAL_BANK_MAPPER_MACROS_SVH
`define SERIAL_BANK_MAPPER_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define SBM_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("sbm check failed");
// next-cycle implication
`define SBM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sbm check failed");
`else
`define SBM_ASSERT_NOW(label, ante, cons)
`define SBM_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ===== rtl/sbm_pkg.sv =====
// Types and constants for the serial bank mapper.
// No dependencies; used by the channel interface users and the top level.
package sbm_pkg;

  typedef enum logic [1:0] {
    RegCtrl = 2'd0,
    RegChr0 = 2'd1,
    RegChr1 = 2'd2,
    RegPrg  = 2'd3
  } bank_reg_e;

  typedef enum logic [1:0] {
    CfgWramFromChr  = 2'd0,
    CfgIgnoreWramEn = 2'd1,
    CfgMirrorFixed  = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    PrgMode32k       = 2'b00,
    PrgMode32kAlt    = 2'b01,
    PrgModeFixFirst  = 2'b10,
    PrgModeFixLast   = 2'b11
  } prg_mode_e;

  localparam int unsigned      CfgIdxW     = 2;
  localparam logic [4:0]       CtlResetVal = 5'h1F;
  localparam logic [4:0]       CtlLoadSet  = 5'h0C;
  localparam logic [2:0]       ShiftLast   = 3'd4;
  localparam logic [32:0]      BusyCycles  = 33'd2;

  typedef struct packed {
    logic        kind;
    logic [1:0]  reg_select;
    logic [7:0]  data;
    logic [31:0] cycle_time;
  } in_word_t;

  typedef struct packed {
    logic       write_ignored;
    logic [5:0] prg_bank_lower;
    logic [5:0] prg_bank_upper;
    logic [4:0] chr_bank_lower;
    logic [4:0] chr_bank_upper;
    logic [1:0] mirroring;
    logic       mirroring_driven;
    logic       wram_enabled;
    logic       wram_bank;
  } out_word_t;

endpackage

// ===== rtl/sbm_stream_if.sv =====
// Valid/ready channel carrying one word of a given payload type.
// Payload types come from sbm_pkg.
interface sbm_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/serial_bank_mapper.sv =====
// Serial bank mapper top level: loader, bank registers and bank decode.
// Depends on sbm_pkg, sbm_stream_if and serial_bank_mapper_macros.svh.
//
// Usage:
//   in_ch takes one bus-write word per handshake (kind, reg_select, data,
//   cycle_time). out_ch returns exactly one word per input word: the
//   ignore flag plus the code/graphics banks, mirroring and work-RAM
//   controls selected by the registers after that write.
//   The result is registered: the word accepted at an edge is shown on
//   out_ch from that edge onward, held in a single output register.
//   Throughput is one word per cycle unless out_ch stalls; the loader and
//   decode are a single pass of logic between state and output registers.
//   in_ch.ready stays high while the output register is empty or being
//   drained in the same cycle, so a stalled receiver holds back at most
//   the one pending word before input is throttled.
//   The user must write configuration (cfg_we_i/cfg_idx_i/cfg_wdata_i) only
//   while idle (not enforced); indexes past the last register are dropped.
//   Reset clears the loader, the reset stamp and the configuration, and
//   loads the control register with 0x1F; the output register empties.
`include "serial_bank_mapper_macros.svh"

module serial_bank_mapper (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [sbm_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic                       cfg_wdata_i,
  sbm_stream_if.sink                 in_ch,
  sbm_stream_if.source               out_ch
);

  logic [4:0]  bank_q [4];
  logic [4:0]  bank_d [4];
  logic [4:0]  shift_val_q, shift_val_d;
  logic [2:0]  shift_cnt_q, shift_cnt_d;
  logic [31:0] stamp_q, stamp_d;
  logic        wram_from_chr_q, ignore_wram_en_q, mirror_fixed_q;
  logic        out_vld_q;
  sbm_pkg::out_word_t out_q, res;

  logic        accept, busy, ignored;
  logic [4:0]  shift_new;
  logic [2:0]  cnt_new;
  logic [4:0]  ctl, c0, c1, pr;
  sbm_pkg::in_word_t w;

  assign w           = in_ch.payload;
  assign in_ch.ready = !out_vld_q || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;

  // busy window compare is done at 33 bits so the stamp never wraps
  assign busy = {1'b0, w.cycle_time} < ({1'b0, stamp_q} + sbm_pkg::BusyCycles);

  assign shift_new = shift_val_q | (5'(w.data[0]) << shift_cnt_q);
  assign cnt_new   = shift_cnt_q + 3'd1;

  always_comb begin
    bank_d      = bank_q;
    shift_val_d = shift_val_q;
    shift_cnt_d = shift_cnt_q;
    stamp_d     = stamp_q;
    ignored     = 1'b0;
    if (accept) begin
      priority if (w.kind) begin
        bank_d[sbm_pkg::RegCtrl] = sbm_pkg::CtlResetVal;
        bank_d[sbm_pkg::RegChr0] = '0;
        bank_d[sbm_pkg::RegChr1] = '0;
        bank_d[sbm_pkg::RegPrg]  = '0;
        shift_val_d = '0;
        shift_cnt_d = '0;
        stamp_d     = '0;
      end else if (busy) begin
        ignored = 1'b1;
      end else if (w.data[7]) begin
        bank_d[sbm_pkg::RegCtrl] = bank_q[sbm_pkg::RegCtrl] | sbm_pkg::CtlLoadSet;
        shift_val_d = '0;
        shift_cnt_d = '0;
        stamp_d     = w.cycle_time;
      end else if (shift_cnt_q == sbm_pkg::ShiftLast) begin
        bank_d[w.reg_select] = shift_new;
        shift_val_d = '0;
        shift_cnt_d = '0;
      end else begin
        shift_val_d = shift_new;
        shift_cnt_d = cnt_new;
      end
    end
  end

  // bank decode from the updated registers
  assign ctl = bank_d[sbm_pkg::RegCtrl];
  assign c0  = bank_d[sbm_pkg::RegChr0];
  assign c1  = bank_d[sbm_pkg::RegChr1];
  assign pr  = bank_d[sbm_pkg::RegPrg];

  always_comb begin
    res = '0;
    res.write_ignored = ignored;
    unique case (sbm_pkg::prg_mode_e'(ctl[3:2]))
      sbm_pkg::PrgModeFixLast: begin
        res.prg_bank_lower = {1'b0, c0[4], pr[3:0]};
        res.prg_bank_upper = {1'b0, c0[4], 4'hF};
      end
      sbm_pkg::PrgModeFixFirst: begin
        res.prg_bank_lower = {1'b0, c0[4], 4'h0};
        res.prg_bank_upper = {1'b0, c0[4], pr[3:0]};
      end
      default: begin
        // 32KB mode: even bank below, odd bank above
        res.prg_bank_lower = {1'b0, c0[4], pr[3:1], 1'b0};
        res.prg_bank_upper = {1'b0, c0[4], pr[3:1], 1'b1};
      end
    endcase
    if (ctl[4]) begin
      res.chr_bank_lower = c0;
      res.chr_bank_upper = c1;
    end else begin
      res.chr_bank_lower = {c0[4:1], 1'b0};
      res.chr_bank_upper = {c0[4:1], 1'b1};
    end
    res.mirroring        = mirror_fixed_q ? 2'd0 : ctl[1:0];
    res.mirroring_driven = !mirror_fixed_q;
    res.wram_enabled     = !pr[4] || ignore_wram_en_q;
    res.wram_bank        = wram_from_chr_q && (ctl[4] ? c0[4] : c0[3]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bank_q[sbm_pkg::RegCtrl] <= sbm_pkg::CtlResetVal;
      bank_q[sbm_pkg::RegChr0] <= '0;
      bank_q[sbm_pkg::RegChr1] <= '0;
      bank_q[sbm_pkg::RegPrg]  <= '0;
      shift_val_q <= '0;
      shift_cnt_q <= '0;
      stamp_q     <= '0;
      out_vld_q   <= 1'b0;
    end else begin
      bank_q      <= bank_d;
      shift_val_q <= shift_val_d;
      shift_cnt_q <= shift_cnt_d;
      stamp_q     <= stamp_d;
      if (accept) begin
        out_vld_q <= 1'b1;
      end else if (out_ch.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_q <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wram_from_chr_q  <= 1'b0;
      ignore_wram_en_q <= 1'b0;
      mirror_fixed_q   <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        sbm_pkg::CfgWramFromChr:  wram_from_chr_q  <= cfg_wdata_i;
        sbm_pkg::CfgIgnoreWramEn: ignore_wram_en_q <= cfg_wdata_i;
        sbm_pkg::CfgMirrorFixed:  mirror_fixed_q   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign out_ch.valid   = out_vld_q;
  assign out_ch.payload = out_q;

  `SBM_ASSERT_NEXT(a_word_out, accept, out_vld_q)
  `SBM_ASSERT_NOW(a_cnt_range, out_vld_q || !out_vld_q, shift_cnt_q <= sbm_pkg::ShiftLast)
  `SBM_ASSERT_NEXT(a_ignored_holds, accept && !w.kind && busy,
                   $stable(shift_cnt_q) && $stable(shift_val_q) && $stable(stamp_q)
                   && out_q.write_ignored)
  `SBM_ASSERT_NEXT(a_loader_reset, accept && !w.kind && !busy && w.data[7],
                   shift_cnt_q == 3'd0 && stamp_q == $past(w.cycle_time)
                   && bank_q[sbm_pkg::RegCtrl][3:2] == 2'b11)
  `SBM_ASSERT_NEXT(a_mapper_reset, accept && w.kind,
                   bank_q[sbm_pkg::RegCtrl] == sbm_pkg::CtlResetVal && stamp_q == '0
                   && !out_q.write_ignored)

endmodule

// ===== test/tb.sv =====
// Self-checking testbench for serial_bank_mapper: a table of directed bus writes, then
// random load sequences, scored against a loader/bank-decode predictor or pinned expectations.
// Depends on sbm_pkg and sbm_stream_if from the RTL.
module tb;
  import sbm_pkg::*;

  typedef struct packed {
    in_word_t  w;
    logic      pinned;
    out_word_t exp;
  } dir_row_t;

  typedef struct packed {
    logic      pinned;
    out_word_t exp;
  } pin_t;

  localparam out_word_t PowerOn = '{write_ignored: 1'b0, prg_bank_lower: 6'd0,
                                    prg_bank_upper: 6'd15, chr_bank_lower: 5'd0,
                                    chr_bank_upper: 5'd0, mirroring: 2'd3,
                                    mirroring_driven: 1'b1, wram_enabled: 1'b1,
                                    wram_bank: 1'b0};
  localparam out_word_t PowerOnIgn = '{write_ignored: 1'b1, prg_bank_lower: 6'd0,
                                       prg_bank_upper: 6'd15, chr_bank_lower: 5'd0,
                                       chr_bank_upper: 5'd0, mirroring: 2'd3,
                                       mirroring_driven: 1'b1, wram_enabled: 1'b1,
                                       wram_bank: 1'b0};

  localparam int NumDirRows = 25;
  // expectations are pinned only while all config bits are zero
  localparam dir_row_t DirRows [NumDirRows] = '{
    '{'{1'b0, RegCtrl, 8'h00, 32'd0}, 1'b1, PowerOnIgn},  // busy window right after reset
    '{'{1'b0, RegPrg,  8'h80, 32'd1}, 1'b1, PowerOnIgn},  // loader reset inside window: dropped
    '{'{1'b0, RegChr0, 8'h80, 32'd2}, 1'b1, PowerOn},
    '{'{1'b0, RegChr1, 8'h01, 32'd3}, 1'b1, PowerOnIgn},
    '{'{1'b0, RegPrg,  8'hFF, 32'd4}, 1'b1, PowerOn},
    // prg <= 0x1D; select only counts on the fifth word
    '{'{1'b0, RegCtrl, 8'h01, 32'd6},  1'b0, '0},
    '{'{1'b0, RegChr0, 8'h7E, 32'd7},  1'b0, '0},
    '{'{1'b0, RegChr1, 8'h41, 32'd8},  1'b0, '0},
    '{'{1'b0, RegCtrl, 8'h03, 32'd9},  1'b0, '0},
    '{'{1'b0, RegPrg,  8'h11, 32'd10}, 1'b0, '0},
    // ctl <= 0: 32KB code, 8KB graphics, mirroring 0
    '{'{1'b0, RegCtrl, 8'h00, 32'd11}, 1'b0, '0},
    '{'{1'b0, RegCtrl, 8'h00, 32'd12}, 1'b0, '0},
    '{'{1'b0, RegCtrl, 8'h00, 32'd13}, 1'b0, '0},
    '{'{1'b0, RegCtrl, 8'h00, 32'd14}, 1'b0, '0},
    '{'{1'b0, RegCtrl, 8'h00, 32'd15}, 1'b0, '0},
    // chr0 <= 0x1F
    '{'{1'b0, RegChr0, 8'h7F, 32'd16}, 1'b0, '0},
    '{'{1'b0, RegChr0, 8'h7F, 32'd17}, 1'b0, '0},
    '{'{1'b0, RegChr0, 8'h7F, 32'd18}, 1'b0, '0},
    '{'{1'b0, RegChr0, 8'h7F, 32'd19}, 1'b0, '0},
    '{'{1'b0, RegChr0, 8'h7F, 32'd20}, 1'b0, '0},
    '{'{1'b1, RegChr1, 8'hAA, 32'd21}, 1'b1, PowerOn},     // mapper reset, stamp back to 0
    '{'{1'b0, RegPrg,  8'h80, 32'd1},  1'b1, PowerOnIgn},
    '{'{1'b0, RegChr1, 8'hC5, 32'hFFFF_FFFF}, 1'b1, PowerOn},
    '{'{1'b0, RegChr0, 8'h01, 32'hFFFF_FFFF}, 1'b1, PowerOnIgn},  // no wrap in window
    '{'{1'b1, RegPrg,  8'hFF, 32'hFFFF_FFFF}, 1'b1, PowerOn}
  };

  // bit 0 wram page from chr, bit 1 ignore wram enable, bit 2 fixed mirroring
  localparam int NumPhases = 6;
  localparam logic [2:0] PhaseCfg [NumPhases] = '{3'b000, 3'b111, 3'b101,
                                                  3'b010, 3'b001, 3'b110};

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we_i;
  logic [CfgIdxW-1:0] cfg_idx_i;
  logic cfg_wdata_i;

  sbm_stream_if #(.payload_t(in_word_t))  in_if ();
  sbm_stream_if #(.payload_t(out_word_t)) out_if ();

  serial_bank_mapper u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_ch       (in_if),
    .out_ch      (out_if)
  );

  always #4 clk_i = ~clk_i;

  // predictor state
  logic [4:0]  bank_q [4];
  logic [4:0]  shift_acc;
  logic [2:0]  shift_n;
  logic [31:0] stamp;
  logic        wram_from_chr, ignore_wram_en, mirror_fixed;

  out_word_t   expected_words [$];
  pin_t        pinned_words [$];
  out_word_t   pred_word;
  pin_t        pin;
  int unsigned mismatches = 0;
  int unsigned words_checked = 0;
  int unsigned words_sent = 0;
  int unsigned src_idle_pct = 0;
  int unsigned sink_idle_pct = 0;
  logic [31:0] now_cyc;

  function automatic void clear_mapper();
    bank_q[RegCtrl] = CtlResetVal;
    bank_q[RegChr0] = '0;
    bank_q[RegChr1] = '0;
    bank_q[RegPrg]  = '0;
    shift_acc = '0;
    shift_n = '0;
    stamp = '0;
  endfunction

  // applies one bus write to the predictor and returns the bank decode after it
  function automatic out_word_t map_write(in_word_t w);
    out_word_t  r;
    logic [4:0] ctl, c0, c1, pr;
    logic [5:0] outer, lo, hi;
    logic       ign;
    ign = 1'b0;
    if (w.kind) begin
      clear_mapper();
    end else if ({1'b0, w.cycle_time} < {1'b0, stamp} + BusyCycles) begin
      ign = 1'b1;
    end else if (w.data[7]) begin
      bank_q[RegCtrl] = bank_q[RegCtrl] | CtlLoadSet;
      shift_acc = '0;
      shift_n = '0;
      stamp = w.cycle_time;
    end else begin
      shift_acc = shift_acc | (5'(w.data[0]) << shift_n);
      if (shift_n == ShiftLast) begin
        bank_q[w.reg_select] = shift_acc;
        shift_acc = '0;
        shift_n = '0;
      end else begin
        shift_n = shift_n + 3'd1;
      end
    end

    ctl = bank_q[RegCtrl];
    c0 = bank_q[RegChr0];
    c1 = bank_q[RegChr1];
    pr = bank_q[RegPrg];
    outer = {1'b0, c0[4], 4'b0};
    case (prg_mode_e'(ctl[3:2]))
      PrgModeFixLast: begin
        lo = {2'b0, pr[3:0]} + outer;
        hi = 6'd15 + outer;
      end
      PrgModeFixFirst: begin
        lo = outer;
        hi = {2'b0, pr[3:0]} + outer;
      end
      default: begin
        lo = {2'b0, pr[3:1], 1'b0} + outer;
        hi = lo + 6'd1;
      end
    endcase
    r.write_ignored = ign;
    r.prg_bank_lower = lo;
    r.prg_bank_upper = hi;
    r.chr_bank_lower = ctl[4] ? c0 : {c0[4:1], 1'b0};
    r.chr_bank_upper = ctl[4] ? c1 : {c0[4:1], 1'b1};
    r.mirroring = mirror_fixed ? 2'd0 : ctl[1:0];
    r.mirroring_driven = ~mirror_fixed;
    r.wram_enabled = ~pr[4] | ignore_wram_en;
    r.wram_bank = wram_from_chr & (ctl[4] ? c0[4] : c0[3]);
    return r;
  endfunction

  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] exp);
    $display("mismatch at word %0d: %s got %0h expected %0h", words_checked, field, got, exp);
    mismatches++;
  endtask

  task automatic check_word(out_word_t got, out_word_t exp);
    if (got.write_ignored !== exp.write_ignored)
      report_mismatch("write_ignored", got.write_ignored, exp.write_ignored);
    if (got.prg_bank_lower !== exp.prg_bank_lower)
      report_mismatch("prg_bank_lower", got.prg_bank_lower, exp.prg_bank_lower);
    if (got.prg_bank_upper !== exp.prg_bank_upper)
      report_mismatch("prg_bank_upper", got.prg_bank_upper, exp.prg_bank_upper);
    if (got.chr_bank_lower !== exp.chr_bank_lower)
      report_mismatch("chr_bank_lower", got.chr_bank_lower, exp.chr_bank_lower);
    if (got.chr_bank_upper !== exp.chr_bank_upper)
      report_mismatch("chr_bank_upper", got.chr_bank_upper, exp.chr_bank_upper);
    if (got.mirroring !== exp.mirroring)
      report_mismatch("mirroring", got.mirroring, exp.mirroring);
    if (got.mirroring_driven !== exp.mirroring_driven)
      report_mismatch("mirroring_driven", got.mirroring_driven, exp.mirroring_driven);
    if (got.wram_enabled !== exp.wram_enabled)
      report_mismatch("wram_enabled", got.wram_enabled, exp.wram_enabled);
    if (got.wram_bank !== exp.wram_bank)
      report_mismatch("wram_bank", got.wram_bank, exp.wram_bank);
  endtask

  // scoreboard: predicts on every accepted input word, checks every output word
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_mapper();
      wram_from_chr = 1'b0;
      ignore_wram_en = 1'b0;
      mirror_fixed = 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgWramFromChr:  wram_from_chr = cfg_wdata_i;
          CfgIgnoreWramEn: ignore_wram_en = cfg_wdata_i;
          CfgMirrorFixed:  mirror_fixed = cfg_wdata_i;
          default: ;
        endcase
      end
      if (in_if.valid && in_if.ready) begin
        pred_word = map_write(in_if.payload);
        pin = pinned_words.pop_front();
        expected_words.push_back(pin.pinned ? pin.exp : pred_word);
      end
      if (out_if.valid && out_if.ready) begin
        if (expected_words.size() == 0)
          report_mismatch("word with no expectation", out_if.payload, '0);
        else
          check_word(out_if.payload, expected_words.pop_front());
        words_checked++;
      end
    end
  end

  always @(posedge clk_i) begin
    out_if.ready <= rst_ni && ($urandom_range(0, 99) >= sink_idle_pct);
  end

  // valid is left high after acceptance so back-to-back words need no toggle
  task automatic send_word(in_word_t w, logic pinned, out_word_t exp);
    if ($urandom_range(0, 99) < src_idle_pct) begin
      in_if.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < src_idle_pct);
    end
    pinned_words.push_back('{pinned, exp});
    in_if.valid <= 1'b1;
    in_if.payload <= w;
    do @(posedge clk_i); while (!in_if.ready);
    words_sent++;
  endtask

  task automatic send_write(logic kind, logic [1:0] sel, logic [7:0] data, int unsigned dt);
    now_cyc = now_cyc + dt;
    send_word('{kind, sel, data, now_cyc}, 1'b0, '0);
  endtask

  task automatic drain_results();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (expected_words.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_cfg(cfg_idx_e idx, logic v);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= v;
    @(posedge clk_i);
  endtask

  task automatic run_random(int unsigned n, logic hold_off);
    int unsigned start, pick, first_dt;
    logic [1:0]  sel;
    logic        paused;
    start = words_sent;
    paused = 1'b0;
    while (words_sent - start < n) begin
      if (hold_off && !paused && (words_sent - start >= n / 2)) begin
        drain_results();
        paused = 1'b1;
      end
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        // five-word load, often preceded by a loader reset to realign the shifter
        sel = 2'($urandom);
        if ($urandom_range(0, 1) == 1) begin
          send_write(1'b0, 2'($urandom), {1'b1, 7'($urandom)}, $urandom_range(2, 5));
          first_dt = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(2, 4);
        end else begin
          first_dt = $urandom_range(1, 3);
        end
        send_write(1'b0, 2'($urandom), {1'b0, 7'($urandom)}, first_dt);
        repeat (4) send_write(1'b0, sel, {1'b0, 7'($urandom)}, $urandom_range(1, 3));
      end else if (pick < 73) begin
        send_write(1'b1, 2'($urandom), 8'($urandom), $urandom_range(0, 3));
      end else if (pick < 78) begin
        now_cyc = $urandom;
        send_write(1'b0, 2'($urandom), 8'($urandom), 0);
      end else begin
        send_write(1'b0, 2'($urandom), 8'($urandom), $urandom_range(0, 3));
      end
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_wdata_i = 1'b0;
    in_if.valid = 1'b0;
    in_if.payload = '0;
    out_if.ready = 1'b0;
    now_cyc = 32'd100;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int p = 0; p < NumPhases; p++) begin
      case (p % 3)
        0: begin src_idle_pct = 23; sink_idle_pct = 87; end
        1: begin src_idle_pct = 87; sink_idle_pct = 23; end
        default: begin src_idle_pct = 0; sink_idle_pct = 0; end
      endcase
      write_cfg(CfgWramFromChr, PhaseCfg[p][0]);
      write_cfg(CfgIgnoreWramEn, PhaseCfg[p][1]);
      write_cfg(CfgMirrorFixed, PhaseCfg[p][2]);
      cfg_we_i <= 1'b0;
      if (p == 0) begin
        foreach (DirRows[i]) send_word(DirRows[i].w, DirRows[i].pinned, DirRows[i].exp);
        run_random(110, 1'b0);
      end else begin
        run_random(143, p == 2);
      end
      drain_results();
    end

    repeat (4) @(posedge clk_i);
    if (mismatches == 0 && expected_words.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("FAIL");
    $finish;
  end

endmodule
